[rtl/tlb4_pkg.sv]
`timescale 1ns / 1ps

package tlb4_pkg;

	// number of sets, a power of two between 16 and 2048
	localparam int SETS    = 2048;
	localparam int WAYS    = 4;
	localparam int SET_W   = $clog2(SETS);
	localparam int WAY_W   = $clog2(WAYS);
	localparam int TAG_W   = 9;
	localparam int FRAME_W = 20;
	localparam int RANK_W  = 2;
	localparam int OFS_W   = 12;
	localparam int ADDR_W  = 32;
	localparam int SET_LSB = 12;
	localparam int TAG_LSB = 23;

	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_FILL   = 1'b1;

	typedef struct packed {
		logic               valid;
		logic [TAG_W-1:0]   tag;
		logic [FRAME_W-1:0] frame;
		logic [RANK_W-1:0]  rank;
	} way_t;

	typedef way_t [WAYS-1:0] row_t;

	typedef struct packed {
		logic               req_type;
		logic [TAG_W-1:0]   tag;
		logic [FRAME_W-1:0] frame;
		logic [OFS_W-1:0]   offset;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [WAY_W-1:0]  way;
		logic [ADDR_W-1:0] phys_addr;
	} res_t;

endpackage

[rtl/tlb_4way_lru_lookup_fill.sv]
`timescale 1ns / 1ps
// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------
// in       | in_valid, in_stall | req_type, virt_addr, fill_phys_addr
// out      | out_valid,out_stall| hit, way_used, result_phys_addr
//
// the set row is read from the single-port-read ram when an item is taken;
// the update stage then compares, updates and writes it back.
// a new item is taken once the previous one has left the update stage.
// after reset a clearing pass writes SETS rows; no item is taken
// meanwhile. out_stall holds the update stage only when the output
// register is still full.

module tlb_4way_lru_lookup_fill (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [31:0] virt_addr,
	input  logic [31:0] fill_phys_addr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [1:0]  way_used,
	output logic [31:0] result_phys_addr
);

	logic                        clearing_q;
	logic [tlb4_pkg::SET_W-1:0]  clr_q;
	logic                        busy_s1;
	tlb4_pkg::req_t              req_s1;
	logic [tlb4_pkg::SET_W-1:0]  set_s1;
	logic                        out_valid_q;
	tlb4_pkg::res_t              out_q;

	logic                        accept;
	logic                        done;
	logic [tlb4_pkg::SET_W-1:0]  in_set;
	tlb4_pkg::req_t              in_req;
	tlb4_pkg::row_t              rd_row;
	tlb4_pkg::row_t              upd_row;
	logic                        upd_we;
	tlb4_pkg::res_t              upd_res;
	logic                        ram_we;
	logic [tlb4_pkg::SET_W-1:0]  ram_waddr;
	tlb4_pkg::row_t              ram_wdata;

	assign in_stall = clearing_q || busy_s1;
	assign accept   = in_valid && !in_stall;
	assign done     = busy_s1 && (!out_valid_q || !out_stall);

	assign in_set          = virt_addr[tlb4_pkg::SET_LSB +: tlb4_pkg::SET_W];
	assign in_req.req_type = req_type;
	assign in_req.tag      = virt_addr[tlb4_pkg::TAG_LSB +: tlb4_pkg::TAG_W];
	assign in_req.frame    = fill_phys_addr[tlb4_pkg::ADDR_W-1 -: tlb4_pkg::FRAME_W];
	assign in_req.offset   = virt_addr[tlb4_pkg::OFS_W-1:0];

	// clearing pass owns the write port until the last row is done
	assign ram_we    = clearing_q || (done && upd_we);
	assign ram_waddr = clearing_q ? clr_q : set_s1;
	assign ram_wdata = clearing_q ? '0 : upd_row;

	tlb4_ram #(
		.DEPTH(tlb4_pkg::SETS),
		.WIDTH($bits(tlb4_pkg::row_t))
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(in_set),
		.rdata(rd_row)
	);

	tlb4_update u_update (
		.row    (rd_row),
		.req    (req_s1),
		.new_row(upd_row),
		.we     (upd_we),
		.res    (upd_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + tlb4_pkg::SET_W'(1);
			if (clr_q == tlb4_pkg::SET_W'(tlb4_pkg::SETS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (accept) begin
			busy_s1 <= 1'b1;
		end else if (done) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= in_req;
			set_s1 <= in_set;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= upd_res;
		end
	end

	assign out_valid        = out_valid_q;
	assign hit              = out_q.hit;
	assign way_used         = out_q.way;
	assign result_phys_addr = out_q.phys_addr;

	a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !busy_s1)
		else $error("item in flight during clearing pass");

	a_done_gives_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_valid_q)
		else $error("finished item not presented");

	a_hit_only_on_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(done && upd_res.hit) |-> (req_s1.req_type == tlb4_pkg::REQ_LOOKUP))
		else $error("hit reported for a fill");

	a_clear_covers_all: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing_q) |-> ($past(clr_q) == tlb4_pkg::SET_W'(tlb4_pkg::SETS - 1)))
		else $error("clearing pass ended early");

	a_write_only_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && !clearing_q) |-> done)
		else $error("row written outside update");

endmodule

[rtl/tlb4_ram.sv]
`timescale 1ns / 1ps

module tlb4_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/tlb4_update.sv]
`timescale 1ns / 1ps

module tlb4_update (
	input  tlb4_pkg::row_t row,
	input  tlb4_pkg::req_t req,
	output tlb4_pkg::row_t new_row,
	output logic           we,
	output tlb4_pkg::res_t res
);

	logic                          lookup;
	logic                          hit_found;
	logic [tlb4_pkg::WAY_W-1:0]    hit_way;
	logic                          inv_found;
	logic [tlb4_pkg::WAY_W-1:0]    inv_way;
	logic [tlb4_pkg::WAY_W-1:0]    vic_way;
	logic [tlb4_pkg::WAY_W-1:0]    sel_way;
	logic                          promote;
	logic [tlb4_pkg::RANK_W-1:0]   orig_rank;

	assign lookup = (req.req_type == tlb4_pkg::REQ_LOOKUP);

	// lowest matching way and lowest invalid way
	always_comb begin
		hit_found = 1'b0;
		hit_way   = '0;
		inv_found = 1'b0;
		inv_way   = '0;
		for (int i = tlb4_pkg::WAYS - 1; i >= 0; i--) begin
			if (row[i].valid && row[i].tag == req.tag) begin
				hit_found = 1'b1;
				hit_way   = tlb4_pkg::WAY_W'(i);
			end
			if (!row[i].valid) begin
				inv_found = 1'b1;
				inv_way   = tlb4_pkg::WAY_W'(i);
			end
		end
	end

	// highest rank, lowest way among ties
	always_comb begin
		vic_way = '0;
		for (int i = 1; i < tlb4_pkg::WAYS; i++) begin
			if (row[i].rank > row[vic_way].rank) begin
				vic_way = tlb4_pkg::WAY_W'(i);
			end
		end
	end

	assign sel_way   = lookup ? hit_way : (inv_found ? inv_way : vic_way);
	assign promote   = lookup ? hit_found : !inv_found;
	assign orig_rank = row[sel_way].rank;

	always_comb begin
		new_row = row;
		if (!lookup) begin
			new_row[sel_way].valid = 1'b1;
			new_row[sel_way].tag   = req.tag;
			new_row[sel_way].frame = req.frame;
			new_row[sel_way].rank  = tlb4_pkg::RANK_W'(sel_way);
		end
		if (promote) begin
			// ranks below the promoted way's old rank move up by one
			for (int i = 0; i < tlb4_pkg::WAYS; i++) begin
				if (tlb4_pkg::WAY_W'(i) != sel_way && row[i].valid
						&& row[i].rank < orig_rank) begin
					new_row[i].rank = row[i].rank + tlb4_pkg::RANK_W'(1);
				end
			end
			new_row[sel_way].rank = '0;
		end
	end

	assign we            = !lookup || hit_found;
	assign res.hit       = lookup && hit_found;
	assign res.way       = (lookup && !hit_found) ? '0 : sel_way;
	assign res.phys_addr = res.hit ? {row[hit_way].frame, req.offset} : '0;

endmodule
